[design/falru_pkg.sv]
`timescale 1ns / 1ps
package falru_pkg;

    localparam int LINES_DEF     = 16;
    localparam int ADDR_BITS_DEF = 16;
    localparam int BLK_ADDR_W    = 16;
    localparam int SLOT_OUT_W    = 4;
    localparam int CNT_OUT_W     = 16;
    localparam int CFG_W         = 5;
    localparam int ACTIVE_RESET  = 16;
    localparam int Q_DEPTH       = 2;

    typedef enum logic {
        BK_LOOK,
        BK_WRITE
    } t_back_state;

    typedef struct packed {
        logic                  valid;
        logic [BLK_ADDR_W-1:0] addr;
    } t_q_head;

endpackage

[design/falru_if.sv]
`timescale 1ns / 1ps
interface falru_in_if;
    import falru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BLK_ADDR_W-1:0] block_address;

    modport source (output valid, output block_address, input ready);
    modport sink   (input valid, input block_address, output ready);
endinterface

interface falru_out_if;
    import falru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] line_slot;
    logic                  evicted_valid;
    logic [BLK_ADDR_W-1:0] evicted_address;
    logic [CNT_OUT_W-1:0]  hit_count;
    logic [CNT_OUT_W-1:0]  miss_count;

    modport source (
        output valid, output hit, output line_slot, output evicted_valid,
        output evicted_address, output hit_count, output miss_count,
        input ready
    );
    modport sink (
        input valid, input hit, input line_slot, input evicted_valid,
        input evicted_address, input hit_count, input miss_count,
        output ready
    );
endinterface

[design/falru_front.sv]
`timescale 1ns / 1ps
module falru_front #(
    parameter int ADDR_BITS = falru_pkg::ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    falru_in_if.sink           i_req,
    input  logic               i_pop,
    output falru_pkg::t_q_head o_head
);
    import falru_pkg::*;

    localparam int TAG_W = (ADDR_BITS < BLK_ADDR_W) ? ADDR_BITS : BLK_ADDR_W;
    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W  = $clog2(Q_DEPTH + 1);

    logic [TAG_W-1:0] r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    logic             push;

    assign i_req.ready = (r_cnt != QC_W'(Q_DEPTH));
    assign push        = i_req.valid && i_req.ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // keep only the address bits in use
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req.block_address[TAG_W-1:0];
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.addr  = BLK_ADDR_W'(r_q[r_rp]);

endmodule

[design/falru_back.sv]
`timescale 1ns / 1ps
module falru_back #(
    parameter int LINES     = falru_pkg::LINES_DEF,
    parameter int ADDR_BITS = falru_pkg::ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [falru_pkg::CFG_W-1:0] i_cfg_wdata,
    input  falru_pkg::t_q_head         i_head,
    output logic                       o_pop,
    falru_out_if.source                o_rsp
);
    import falru_pkg::*;

    localparam int TAG_W   = (ADDR_BITS < BLK_ADDR_W) ? ADDR_BITS : BLK_ADDR_W;
    localparam int SLOT_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W   = $clog2(LINES + 1);
    localparam int CAP_RST = (ACTIVE_RESET > LINES) ? LINES : ACTIVE_RESET;

    t_back_state r_state, n_state;

    logic [TAG_W-1:0]  r_tag [LINES];
    logic [SLOT_W-1:0] r_age [LINES];
    logic [SLOT_W-1:0] n_age [LINES];
    logic [CNT_W-1:0]  r_filled, r_cap;
    logic [CNT_OUT_W-1:0] r_hits, r_misses;

    logic [TAG_W-1:0]  r_addr;
    logic              r_hit;
    logic              r_fill;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_slot_age;
    logic [TAG_W-1:0]  r_ev_tag;

    logic                  r_ov;
    logic                  r_o_hit;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_ev_valid;
    logic [BLK_ADDR_W-1:0] r_o_ev_addr;
    logic [CNT_OUT_W-1:0]  r_o_hits, r_o_misses;

    logic [TAG_W-1:0]  head_tag;
    logic [LINES-1:0]  live, match, victim, sel;
    logic              lk_hit, lk_fill;
    logic [SLOT_W-1:0] lk_slot, lk_idx, lk_age;
    logic [TAG_W-1:0]  lk_ev_tag;

    logic                 do_write;
    logic [CNT_W-1:0]     filled_after;
    logic                 wr_ev;
    logic [CNT_OUT_W-1:0] hits_nx, misses_nx;
    logic [CNT_W-1:0]     cfg_eff;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    // lookup on the queue head
    always_comb begin
        head_tag  = i_head.addr[TAG_W-1:0];
        lk_idx    = '0;
        lk_age    = '0;
        lk_ev_tag = '0;
        for (int i = 0; i < LINES; i++) begin
            live[i]   = CNT_W'(i) < r_filled;
            match[i]  = live[i] && (r_tag[i] == head_tag);
            victim[i] = live[i] && (CNT_W'(r_age[i]) == r_filled - CNT_W'(1));
        end
        lk_hit = |match;
        sel    = lk_hit ? match : victim;
        for (int i = 0; i < LINES; i++) begin
            if (sel[i]) begin
                lk_idx = lk_idx | SLOT_W'(i);
                lk_age = lk_age | r_age[i];
            end
            if (victim[i]) begin
                lk_ev_tag = lk_ev_tag | r_tag[i];
            end
        end
        lk_fill = !lk_hit && (r_filled < r_cap);
        lk_slot = lk_fill ? r_filled[SLOT_W-1:0] : lk_idx;
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        do_write = 1'b0;
        unique case (r_state)
            BK_LOOK: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_WRITE;
                end
            end
            BK_WRITE: begin
                if (!r_ov || o_rsp.ready) begin
                    do_write = 1'b1;
                    n_state  = BK_LOOK;
                end
            end
        endcase
    end

    // age update and counters for the request in flight
    always_comb begin
        filled_after = r_fill ? r_filled + CNT_W'(1) : r_filled;
        wr_ev        = !r_hit && !r_fill;
        hits_nx      = r_hits;
        misses_nx    = r_misses;
        if (r_hit) begin
            if (r_hits != '1) hits_nx = r_hits + CNT_OUT_W'(1);
        end else begin
            if (r_misses != '1) misses_nx = r_misses + CNT_OUT_W'(1);
        end
        for (int i = 0; i < LINES; i++) begin
            n_age[i] = r_age[i];
            if (SLOT_W'(i) == r_slot) begin
                n_age[i] = '0;
            end else if ((CNT_W'(i) < filled_after) && (r_fill || (r_age[i] < r_slot_age))) begin
                n_age[i] = r_age[i] + SLOT_W'(1);
            end
        end
    end

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_eff = CNT_W'(1);
        end else if (int'(i_cfg_wdata) > LINES) begin
            cfg_eff = CNT_W'(LINES);
        end else begin
            cfg_eff = CNT_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_LOOK;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_cap    <= CNT_W'(CAP_RST);
            r_hits   <= '0;
            r_misses <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < LINES; i++) r_age[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap    <= cfg_eff;
                r_filled <= '0;
                for (int i = 0; i < LINES; i++) r_age[i] <= '0;
            end else if (do_write) begin
                r_filled <= filled_after;
                for (int i = 0; i < LINES; i++) r_age[i] <= n_age[i];
            end
            if (do_write) begin
                r_hits   <= hits_nx;
                r_misses <= misses_nx;
                r_ov     <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr     <= head_tag;
            r_hit      <= lk_hit;
            r_fill     <= lk_fill;
            r_slot     <= lk_slot;
            r_slot_age <= lk_age;
            r_ev_tag   <= lk_ev_tag;
        end
        if (do_write) begin
            r_tag[r_slot] <= r_addr;
            r_o_hit       <= r_hit;
            r_o_slot      <= r_slot;
            r_o_ev_valid  <= wr_ev;
            r_o_ev_addr   <= wr_ev ? BLK_ADDR_W'(r_ev_tag) : '0;
            r_o_hits      <= hits_nx;
            r_o_misses    <= misses_nx;
        end
    end

    assign slot_ext              = {{SLOT_OUT_W{1'b0}}, r_o_slot};
    assign o_rsp.valid           = r_ov;
    assign o_rsp.hit             = r_o_hit;
    assign o_rsp.line_slot       = slot_ext[SLOT_OUT_W-1:0];
    assign o_rsp.evicted_valid   = r_o_ev_valid;
    assign o_rsp.evicted_address = r_o_ev_addr;
    assign o_rsp.hit_count       = r_o_hits;
    assign o_rsp.miss_count      = r_o_misses;

endmodule

[design/fully_associative_lru_cache_top.sv]
`timescale 1ns / 1ps
// Fully associative cache lookup with LRU replacement.
// i_req carries one block address per request (valid/ready). o_rsp returns
// one response per request: hit, line, eviction and saturating hit and miss
// counts. i_cfg_we with i_cfg_wdata writes the active line count; a write
// empties the store and keeps the counters. The user issues it only while
// idle; the block does not enforce this. Requests enter a two-entry queue;
// the lookup engine then compares the head against all lines in parallel
// and, in a separate update step, writes the ages, line addresses and
// response register. It finishes one request before it pops the next; a
// response passes the queue, the lookup registers and the response register.
// A stalled o_rsp holds its response; the engine waits in its update step
// while the queue keeps taking requests until its two entries are full.
// Reset (synchronous, active low) empties the store, clears the counters
// and sets the active line count to 16 (limited to LINES).
module fully_associative_lru_cache_top #(
    parameter int LINES     = falru_pkg::LINES_DEF,
    parameter int ADDR_BITS = falru_pkg::ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [falru_pkg::CFG_W-1:0] i_cfg_wdata,
    falru_in_if.sink                    i_req,
    falru_out_if.source                 o_rsp
);
    import falru_pkg::*;

    t_q_head head;
    logic    pop;

    falru_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    falru_back #(
        .LINES     (LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

[tb/fully_associative_lru_cache_top_tb.sv]
`timescale 1ns / 1ps
module fully_associative_lru_cache_top_tb;
    import falru_pkg::*;

    localparam int EXP_DEPTH = 64;
    localparam int POOL_MAX  = 2 * LINES_DEF + 3;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] line_slot;
        logic                  evicted_valid;
        logic [BLK_ADDR_W-1:0] evicted_address;
        logic [CNT_OUT_W-1:0]  hit_count;
        logic [CNT_OUT_W-1:0]  miss_count;
    } t_lookup_result;

    class lru_cache_shadow;
        logic [BLK_ADDR_W-1:0] line_address [LINES_DEF];
        int unsigned           line_age [LINES_DEF];
        int unsigned           lines_filled;
        int unsigned           hits_total;
        int unsigned           misses_total;
        logic [CFG_W-1:0]      active_lines;
        t_lookup_result        expected_lookups [EXP_DEPTH];
        int unsigned           exp_head;
        int unsigned           exp_tail;
        int                    mismatches;

        function new();
            active_lines = CFG_W'(ACTIVE_RESET);
            hits_total   = 0;
            misses_total = 0;
            mismatches   = 0;
            exp_head     = 0;
            exp_tail     = 0;
            clear_lines();
        endfunction

        function int unsigned pending();
            return exp_tail - exp_head;
        endfunction

        function void clear_lines();
            lines_filled = 0;
            foreach (line_age[i]) line_age[i] = 0;
        endfunction

        function void write_active_lines(logic [CFG_W-1:0] value);
            active_lines = value;
            clear_lines();
        endfunction

        function int unsigned capacity();
            int unsigned n;
            n = active_lines;
            if (n == 0) n = 1;
            if (n > LINES_DEF) n = LINES_DEF;
            return n;
        endfunction

        // age every filled line younger than limit, then make slot the newest
        function void promote(int unsigned slot, int unsigned limit);
            for (int unsigned i = 0; i < lines_filled; i++) begin
                if (i != slot && line_age[i] < limit) line_age[i]++;
            end
            line_age[slot] = 0;
        endfunction

        function void note_request(logic [BLK_ADDR_W-1:0] addr);
            t_lookup_result r;
            int unsigned    slot;
            int unsigned    oldest;
            bit             found;
            r     = '0;
            slot  = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < lines_filled; i++) begin
                if (!found && line_address[i] == addr) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                promote(slot, line_age[slot]);
                if (hits_total < 16'hFFFF) hits_total++;
            end else begin
                if (lines_filled < capacity()) begin
                    slot = lines_filled;
                    lines_filled++;
                    line_address[slot] = addr;
                    promote(slot, LINES_DEF + 1);
                end else begin
                    oldest = 0;
                    for (int unsigned i = 0; i < lines_filled; i++) begin
                        if (line_age[i] > oldest || i == 0) begin
                            slot   = i;
                            oldest = line_age[i];
                        end
                    end
                    r.evicted_valid   = 1'b1;
                    r.evicted_address = line_address[slot];
                    line_address[slot] = addr;
                    promote(slot, line_age[slot]);
                end
                if (misses_total < 16'hFFFF) misses_total++;
            end
            r.hit        = found;
            r.line_slot  = SLOT_OUT_W'(slot);
            r.hit_count  = CNT_OUT_W'(hits_total);
            r.miss_count = CNT_OUT_W'(misses_total);
            expected_lookups[exp_tail % EXP_DEPTH] = r;
            exp_tail++;
        endfunction

        function void report(string what, t_lookup_result exp_r, t_lookup_result got);
            mismatches++;
            $display("%0t: %s exp hit=%0b slot=%0d ev=%0b/%h hits=%0d misses=%0d",
                     $time, what, exp_r.hit, exp_r.line_slot, exp_r.evicted_valid,
                     exp_r.evicted_address, exp_r.hit_count, exp_r.miss_count,
                     "\n%0t: %s got hit=%0b slot=%0d ev=%0b/%h hits=%0d misses=%0d",
                     $time, what, got.hit, got.line_slot, got.evicted_valid,
                     got.evicted_address, got.hit_count, got.miss_count);
        endfunction

        function void check_response(t_lookup_result got);
            t_lookup_result exp_r;
            if (pending() == 0) begin
                report("unexpected response", '0, got);
            end else begin
                exp_r = expected_lookups[exp_head % EXP_DEPTH];
                exp_head++;
                if (got !== exp_r) report("response mismatch", exp_r, got);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    bit               pace_on;

    falru_in_if  req_if ();
    falru_out_if rsp_if ();

    lru_cache_shadow shadow = new();

    fully_associative_lru_cache_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // response side back-pressure
    initial begin
        int unsigned n;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            rsp_if.ready <= 1'b1;
            if (!pace_on) begin
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                n = gap_len();
                if (n > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.hit             = rsp_if.hit;
            got.line_slot       = rsp_if.line_slot;
            got.evicted_valid   = rsp_if.evicted_valid;
            got.evicted_address = rsp_if.evicted_address;
            got.hit_count       = rsp_if.hit_count;
            got.miss_count      = rsp_if.miss_count;
            shadow.check_response(got);
        end
    end

    task automatic send_request(logic [BLK_ADDR_W-1:0] addr);
        req_if.valid         <= 1'b1;
        req_if.block_address <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.note_request(addr);
    endtask

    task automatic hold_requests(int unsigned n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_active_lines(logic [CFG_W-1:0] value);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow.write_active_lines(value);
    endtask

    task automatic run_lookups(int unsigned count, bit paced);
        logic [BLK_ADDR_W-1:0] pool [POOL_MAX];
        int unsigned           pool_size;
        logic [BLK_ADDR_W-1:0] addr;
        pool_size = $urandom_range(1, 2 * shadow.capacity() + 3);
        for (int unsigned j = 0; j < pool_size; j++)
            pool[j] = BLK_ADDR_W'($urandom_range(0, 65535));
        pace_on = paced;
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 80)
                addr = pool[$urandom_range(0, pool_size - 1)];
            else
                addr = BLK_ADDR_W'($urandom_range(0, 65535));
            send_request(addr);
            if (paced) hold_requests(gap_len());
            if (k == count / 2 && $urandom_range(0, 3) == 0) drain_responses();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] plan [9];
        int unsigned      waited;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        req_if.valid         = 1'b0;
        req_if.block_address = '0;
        pace_on              = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset line count
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'hA5A5);
        send_request(16'h5A5A);
        // two lines: fill, hit, evict oldest
        write_active_lines(5'd2);
        send_request(16'h0001);
        send_request(16'h0002);
        send_request(16'h0001);
        send_request(16'h0003);
        send_request(16'h0002);
        send_request(16'h0003);
        // zero behaves as one line
        write_active_lines(5'd0);
        send_request(16'h0007);
        send_request(16'h0007);
        send_request(16'h0008);
        send_request(16'h0007);
        // above the line limit behaves as the full cache
        write_active_lines(5'd31);
        send_request(16'h8000);
        send_request(16'h0001);
        send_request(16'h8000);

        plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd9,
                 CFG_W'($urandom_range(0, 31))};
        foreach (plan[p]) begin
            write_active_lines(plan[p]);
            run_lookups(72, p != 3);
        end

        req_if.valid <= 1'b0;
        waited = 0;
        while (shadow.pending() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (shadow.pending() != 0) begin
            shadow.mismatches += shadow.pending();
            $display("%0t: %0d responses missing", $time, shadow.pending());
        end
        if (shadow.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
